// ===== src/mcps_pkg.sv =====
// Shared constants and types for the multi-channel PWM slew limiter.
// No dependencies; used by the top level through scoped names.
`timescale 1ns / 1ps

package mcps_pkg;

  // Channel count and channel roles.
  localparam int NUM_CHANNELS_DEF = 4;
  localparam int CH_FRONT = 0;
  localparam int CH_LEFT  = 1;
  localparam int CH_RIGHT = 2;

  // Field widths fixed by the interface.
  localparam int LEVEL_W = 9;
  localparam int STEP_W  = 8;
  localparam int GAIN_W  = 8;
  localparam int PW_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Working width for the level update (holds level plus or minus a step).
  localparam int WORK_W = 11;
  // Product and offset sum widths.
  localparam int PROD_W = LEVEL_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  // Band within which the level moves by one, and the ceiling with pilot speed.
  localparam int NEAR_BAND  = 10;
  localparam int SPEED_CEIL = 100;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRONT_STEP  = 3'd0,
    REG_SIDE_STEP   = 3'd1,
    REG_SIDE_MAX    = 3'd2,
    REG_SIDE_MIN    = 3'd3,
    REG_FB_MAX      = 3'd4,
    REG_FB_MIN      = 3'd5,
    REG_GAIN        = 3'd6,
    REG_ZERO_OFFSET = 3'd7
  } cfg_reg_t;

  // Register reset values.
  localparam logic [STEP_W-1:0]         FRONT_STEP_RST  = 8'd2;
  localparam logic [STEP_W-1:0]         SIDE_STEP_RST   = 8'd2;
  localparam logic signed [LEVEL_W-1:0] SIDE_MAX_RST    = 9'sd50;
  localparam logic signed [LEVEL_W-1:0] SIDE_MIN_RST    = 9'sd0;
  localparam logic signed [LEVEL_W-1:0] FB_MAX_RST      = 9'sd50;
  localparam logic signed [LEVEL_W-1:0] FB_MIN_RST      = 9'sd0;
  localparam logic [GAIN_W-1:0]         GAIN_RST        = 8'd5;
  localparam logic [PW_W-1:0]           ZERO_OFFSET_RST = 16'd1500;

endpackage

// ===== src/multi_channel_pwm_slew_limiter.sv =====
// Top level of the multi-channel PWM slew limiter: level memory, update
// pipeline, pulse width scaling and configuration registers. Uses mcps_pkg.
`timescale 1ns / 1ps

// The block keeps one level per motor channel and, for every item, steps the
// named channel's level toward its target, clamps it, and returns the new
// level together with the pulse width level*gain+zero_offset saturated to
// 16 bits. It takes one item per clock cycle, back to back, for any mix of
// channels, as long as the result port is not stalled. The levels sit in a
// small memory with a registered read port: the read is issued as the item is
// accepted, the update and write-back happen as the item leaves stage 1, and
// the write of the item just ahead is forwarded when both name the same
// channel. Each memory entry has a valid bit cleared by reset, so an entry not
// yet written reads as level zero and no clearing pass is needed. Each stage
// has its own valid flag and moves whenever the stage after it is free, so a
// result that waits at the output does not stop items from entering until the
// pipeline is full. Neither channel is ready while reset is high. Outside
// reset, configuration writes are always taken at once and should only be made
// while no item is in flight.

module multi_channel_pwm_slew_limiter #(
  parameter int NUM_CHANNELS = mcps_pkg::NUM_CHANNELS_DEF,
  parameter int CH_W = $clog2(NUM_CHANNELS)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration write channel.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mcps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mcps_pkg::CFG_DATA_W-1:0]        cfg_data,
  // Input items.
  input  logic                                   item_valid,
  output logic                                   item_ready,
  input  logic [CH_W-1:0]                        channel,
  input  logic signed [mcps_pkg::LEVEL_W-1:0]    target,
  input  logic signed [mcps_pkg::LEVEL_W-1:0]    pilot_speed,
  // Result items.
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic [mcps_pkg::PW_W-1:0]              pulse_width,
  output logic signed [mcps_pkg::LEVEL_W-1:0]    level
);

  localparam int LW = mcps_pkg::LEVEL_W;
  localparam int WW = mcps_pkg::WORK_W;
  localparam int PW = mcps_pkg::PROD_W;
  localparam int SW = mcps_pkg::SUM_W;

  // Configuration registers.
  logic [mcps_pkg::STEP_W-1:0]  front_step;
  logic [mcps_pkg::STEP_W-1:0]  side_step;
  logic signed [LW-1:0]         side_max;
  logic signed [LW-1:0]         side_min;
  logic signed [LW-1:0]         fb_max;
  logic signed [LW-1:0]         fb_min;
  logic [mcps_pkg::GAIN_W-1:0]  gain;
  logic [mcps_pkg::PW_W-1:0]    zero_offset;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_step  <= mcps_pkg::FRONT_STEP_RST;
      side_step   <= mcps_pkg::SIDE_STEP_RST;
      side_max    <= mcps_pkg::SIDE_MAX_RST;
      side_min    <= mcps_pkg::SIDE_MIN_RST;
      fb_max      <= mcps_pkg::FB_MAX_RST;
      fb_min      <= mcps_pkg::FB_MIN_RST;
      gain        <= mcps_pkg::GAIN_RST;
      zero_offset <= mcps_pkg::ZERO_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mcps_pkg::cfg_reg_t'(cfg_index))
        mcps_pkg::REG_FRONT_STEP:  front_step  <= cfg_data[mcps_pkg::STEP_W-1:0];
        mcps_pkg::REG_SIDE_STEP:   side_step   <= cfg_data[mcps_pkg::STEP_W-1:0];
        mcps_pkg::REG_SIDE_MAX:    side_max    <= $signed(cfg_data[LW-1:0]);
        mcps_pkg::REG_SIDE_MIN:    side_min    <= $signed(cfg_data[LW-1:0]);
        mcps_pkg::REG_FB_MAX:      fb_max      <= $signed(cfg_data[LW-1:0]);
        mcps_pkg::REG_FB_MIN:      fb_min      <= $signed(cfg_data[LW-1:0]);
        mcps_pkg::REG_GAIN:        gain        <= cfg_data[mcps_pkg::GAIN_W-1:0];
        mcps_pkg::REG_ZERO_OFFSET: zero_offset <= cfg_data[mcps_pkg::PW_W-1:0];
      endcase
    end
  end

  // Pipeline handshake. Each stage moves when the one after it is empty or
  // moving, so bubbles close up behind a stalled output.
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic accept, adv1;

  assign rdy3       = !result_valid || result_ready;
  assign rdy2       = !v3 || rdy3;
  assign rdy1       = !v2 || rdy2;
  assign item_ready = !rst && (!v1 || rdy1);
  assign accept     = item_valid && item_ready;
  assign adv1       = v1 && rdy1;

  // Level memory with a registered read and a valid bit per entry.
  logic signed [LW-1:0] mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] mem_vld;
  logic signed [LW-1:0] rd_data;
  logic rd_vld;

  // Stage 1: item fields, read data and the forwarded write of the item ahead.
  logic [CH_W-1:0]      s1_ch;
  logic signed [LW-1:0] s1_tgt;
  logic signed [LW-1:0] s1_spd;
  logic                 fwd_hit;
  logic signed [LW-1:0] fwd_val;
  logic signed [LW-1:0] new_lv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (adv1) begin
      mem_vld[s1_ch] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      mem[s1_ch] <= new_lv;
    end
    if (accept) begin
      rd_data <= mem[channel];
      rd_vld  <= mem_vld[channel];
      fwd_hit <= adv1 && (s1_ch == channel);
      fwd_val <= new_lv;
      s1_ch   <= channel;
      s1_tgt  <= target;
      s1_spd  <= pilot_speed;
    end
  end

  // Level update and clamping.
  logic signed [WW-1:0] old_w, tgt_w, spd_w, up_w, dn_w, step_w, stepped;
  logic signed [WW-1:0] smax_w, smin_w, fmax_w, fmin_w, lim_w, clamped;
  logic signed [LW-1:0] old_lv;
  logic is_front, is_side;

  always_comb begin
    old_lv   = fwd_hit ? fwd_val : (rd_vld ? rd_data : '0);
    is_front = (s1_ch == CH_W'(mcps_pkg::CH_FRONT));
    is_side  = (s1_ch == CH_W'(mcps_pkg::CH_LEFT)) || (s1_ch == CH_W'(mcps_pkg::CH_RIGHT));
    old_w    = {{(WW-LW){old_lv[LW-1]}}, old_lv};
    tgt_w    = {{(WW-LW){s1_tgt[LW-1]}}, s1_tgt};
    spd_w    = {{(WW-LW){s1_spd[LW-1]}}, s1_spd};
    smax_w   = {{(WW-LW){side_max[LW-1]}}, side_max};
    smin_w   = {{(WW-LW){side_min[LW-1]}}, side_min};
    fmax_w   = {{(WW-LW){fb_max[LW-1]}}, fb_max};
    fmin_w   = {{(WW-LW){fb_min[LW-1]}}, fb_min};
    up_w     = old_w + WW'(mcps_pkg::NEAR_BAND);
    dn_w     = old_w - WW'(mcps_pkg::NEAR_BAND);
    step_w   = is_front ? {{(WW-mcps_pkg::STEP_W){1'b0}}, front_step}
                        : {{(WW-mcps_pkg::STEP_W){1'b0}}, side_step};

    priority if (s1_tgt == '0) begin
      stepped = '0;
    end else if (tgt_w > old_w) begin
      stepped = (up_w > tgt_w) ? old_w + WW'(1) : old_w + step_w;
    end else if (tgt_w < old_w) begin
      // The front channel drops straight to a lower target.
      if (is_front) begin
        stepped = tgt_w;
      end else if (dn_w < tgt_w) begin
        stepped = old_w - WW'(1);
      end else begin
        stepped = old_w - {{(WW-mcps_pkg::STEP_W){1'b0}}, side_step};
      end
    end else begin
      stepped = old_w;
    end

    // Side channels: upper limit shifts by the pilot speed when it is nonzero,
    // then the lower limit wins, then a fixed ceiling applies if the speed is nonzero.
    clamped = stepped;
    if (is_side) begin
      lim_w = (s1_spd == '0) ? smax_w : smax_w + spd_w;
      if (clamped > lim_w) clamped = lim_w;
      if (clamped < smin_w) clamped = smin_w;
      if ((s1_spd != '0) && (clamped > WW'(mcps_pkg::SPEED_CEIL))) begin
        clamped = WW'(mcps_pkg::SPEED_CEIL);
      end
    end else begin
      lim_w = fmax_w;
      if (clamped > fmax_w) clamped = fmax_w;
      if (clamped < fmin_w) clamped = fmin_w;
    end
    new_lv = clamped[LW-1:0];
  end

  // Stage 2 holds the new level, stage 3 the product, the output stage the
  // saturated pulse width.
  logic signed [LW-1:0] s2_lv, s3_lv;
  logic signed [PW-1:0] s3_prod;
  logic signed [SW-1:0] sum;
  logic [mcps_pkg::PW_W-1:0] pw_sat;

  always_comb begin
    sum = {s3_prod[PW-1], s3_prod} + {{(SW-mcps_pkg::PW_W){1'b0}}, zero_offset};
    priority if (sum < 0) begin
      pw_sat = '0;
    end else if (sum > $signed({{(SW-mcps_pkg::PW_W){1'b0}}, {mcps_pkg::PW_W{1'b1}}})) begin
      pw_sat = '1;
    end else begin
      pw_sat = sum[mcps_pkg::PW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) v1 <= item_valid;
      if (rdy1)       v2 <= v1;
      if (rdy2)       v3 <= v2;
      if (rdy3)       result_valid <= v3;
    end
  end

  // The product is formed at full width; the level is sign-extended and the
  // gain zero-extended, so the low bits hold the signed product.
  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_lv <= new_lv;
    end
    if (v2 && rdy2) begin
      s3_lv   <= s2_lv;
      s3_prod <= {{(PW-LW){s2_lv[LW-1]}}, s2_lv} *
                 {{(PW-mcps_pkg::GAIN_W){1'b0}}, gain};
    end
    if (v3 && rdy3) begin
      level       <= s3_lv;
      pulse_width <= pw_sat;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the multi-channel PWM slew limiter.
// Drives level commands and register writes, predicts levels and pulse widths.
// Depends on src/mcps_pkg.sv and src/multi_channel_pwm_slew_limiter.sv.
`timescale 1ns / 1ps

module tb_top;

  // The package names front, left and right; back is the remaining channel.
  localparam int CH_BACK = 3;

  // Stimulus shape.
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 140;
  localparam int IDLE_PCT     = 35;
  // Items numbered in this window are sent and taken with no random idling.
  localparam int CALM_LO      = 300;
  localparam int CALM_HI      = 480;
  // Cycles to keep watching the result port once nothing is owed.
  localparam int DRAIN_CYCLES = 20;

  // One entry of the command list: either a register write or a level item.
  typedef struct {
    bit                                  is_write;
    mcps_pkg::cfg_reg_t                  reg_idx;
    logic [mcps_pkg::CFG_DATA_W-1:0]     reg_data;
    logic [1:0]                          ch;
    logic signed [mcps_pkg::LEVEL_W-1:0] tgt;
    logic signed [mcps_pkg::LEVEL_W-1:0] spd;
  } motor_cmd_t;

  // What one item should produce at the result port.
  typedef struct {
    logic [mcps_pkg::PW_W-1:0]           pw;
    logic signed [mcps_pkg::LEVEL_W-1:0] lv;
  } motor_out_t;

  logic                                clk          = 1'b0;
  logic                                rst          = 1'b1;
  logic                                cfg_valid    = 1'b0;
  logic                                cfg_ready;
  logic [mcps_pkg::CFG_IDX_W-1:0]      cfg_index    = '0;
  logic [mcps_pkg::CFG_DATA_W-1:0]     cfg_data     = '0;
  logic                                item_valid   = 1'b0;
  logic                                item_ready;
  logic [1:0]                          channel      = '0;
  logic signed [mcps_pkg::LEVEL_W-1:0] target       = '0;
  logic signed [mcps_pkg::LEVEL_W-1:0] pilot_speed  = '0;
  logic                                result_valid;
  logic                                result_ready = 1'b0;
  logic [mcps_pkg::PW_W-1:0]           pulse_width;
  logic signed [mcps_pkg::LEVEL_W-1:0] level;

  motor_cmd_t cmd_q[$];
  motor_out_t pwm_expect_q[$];

  // results_owed is written only by the monitor, with a nonblocking assignment,
  // so the driver and the end sequence always see a settled value.
  int   results_owed = 0;
  int   sent_cnt     = 0;
  int   got_cnt      = 0;
  int   err_cnt      = 0;
  logic stim_done    = 1'b0;

  // Shadow of the block: the kept level of each channel and the registers.
  int lvl_mem [4];
  int step_front_q, step_side_q;
  int side_hi_q, side_lo_q, fb_hi_q, fb_lo_q;
  int gain_q, offset_q;

  multi_channel_pwm_slew_limiter u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .channel      (channel),
    .target       (target),
    .pilot_speed  (pilot_speed),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pulse_width  (pulse_width),
    .level        (level)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Each mismatch prints one line and is counted.
  task automatic flag_mismatch(input string msg);
    err_cnt++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic queue_level(input int ch, input int tgt, input int spd);
    motor_cmd_t c;
    c.is_write = 1'b0;
    c.reg_idx  = mcps_pkg::REG_FRONT_STEP;
    c.reg_data = '0;
    c.ch       = ch[1:0];
    c.tgt      = tgt[mcps_pkg::LEVEL_W-1:0];
    c.spd      = spd[mcps_pkg::LEVEL_W-1:0];
    cmd_q.push_back(c);
  endtask

  // Bits above a register's width are don't-care, so they are filled at random.
  task automatic queue_reg(input mcps_pkg::cfg_reg_t r, input int value);
    motor_cmd_t c;
    logic [mcps_pkg::CFG_DATA_W-1:0] junk;
    junk       = mcps_pkg::CFG_DATA_W'($urandom);
    c.is_write = 1'b1;
    c.reg_idx  = r;
    c.ch       = '0;
    c.tgt      = '0;
    c.spd      = '0;
    case (r)
      mcps_pkg::REG_ZERO_OFFSET: c.reg_data = value[mcps_pkg::CFG_DATA_W-1:0];
      mcps_pkg::REG_FRONT_STEP, mcps_pkg::REG_SIDE_STEP, mcps_pkg::REG_GAIN:
        c.reg_data = {junk[mcps_pkg::CFG_DATA_W-1:mcps_pkg::STEP_W],
                      value[mcps_pkg::STEP_W-1:0]};
      default: c.reg_data = {junk[mcps_pkg::CFG_DATA_W-1:mcps_pkg::LEVEL_W],
                             value[mcps_pkg::LEVEL_W-1:0]};
    endcase
    cmd_q.push_back(c);
  endtask

  // Targets lean toward zero, the extremes and small values near the band.
  function automatic int pick_level();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 0;
    if (roll < 20) return ($urandom_range(1) != 0) ? 255 : -255;
    if (roll < 35) return int'($urandom_range(24)) - 12;
    return int'($urandom_range(510)) - 255;
  endfunction

  // A zero speed selects the plain side clamp, so it comes up often.
  function automatic int pick_speed();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) return 0;
    if (roll < 45) return ($urandom_range(1) != 0) ? 255 : -255;
    return int'($urandom_range(510)) - 255;
  endfunction

  // Steps the shadow level of one channel and works out the result item.
  // Sums run at integer width, so a coarse step may leave 9 bits before the
  // clamps bring it back.
  function automatic motor_out_t slew_and_scale(input logic [1:0] ch, input int tgt,
                                                input int spd);
    motor_out_t r;
    int lv;
    int pw;
    lv = lvl_mem[ch];
    if (tgt == 0) begin
      lv = 0;
    end else if (tgt > lv) begin
      if (lv + mcps_pkg::NEAR_BAND > tgt) lv = lv + 1;
      else lv = lv + ((ch == mcps_pkg::CH_FRONT) ? step_front_q : step_side_q);
    end else if (tgt < lv) begin
      if (ch == mcps_pkg::CH_FRONT) lv = tgt;
      else if (lv - mcps_pkg::NEAR_BAND < tgt) lv = lv - 1;
      else lv = lv - step_side_q;
    end

    if (ch == mcps_pkg::CH_LEFT || ch == mcps_pkg::CH_RIGHT) begin
      if (spd == 0) begin
        if (lv > side_hi_q) lv = side_hi_q;
        if (lv < side_lo_q) lv = side_lo_q;
      end else begin
        if (lv > side_hi_q + spd) lv = side_hi_q + spd;
        if (lv < side_lo_q) lv = side_lo_q;
        if (lv > mcps_pkg::SPEED_CEIL) lv = mcps_pkg::SPEED_CEIL;
      end
    end else begin
      if (lv > fb_hi_q) lv = fb_hi_q;
      if (lv < fb_lo_q) lv = fb_lo_q;
    end
    lvl_mem[ch] = lv;

    pw = lv * gain_q + offset_q;
    if (pw < 0) pw = 0;
    if (pw > 65535) pw = 65535;
    r.pw = pw[mcps_pkg::PW_W-1:0];
    r.lv = lv[mcps_pkg::LEVEL_W-1:0];
    return r;
  endfunction

  // Driver. Items are offered with random gaps; a register write waits until
  // every result owed has been taken, so the block is idle when it lands.
  always @(posedge clk) begin : drive_proc
    motor_cmd_t c;
    logic       nxt_item_valid;
    logic       nxt_cfg_valid;
    bit         took_item;
    bit         calm_tx;
    if (rst) begin
      item_valid <= 1'b0;
      cfg_valid  <= 1'b0;
    end else begin
      took_item      = item_valid && item_ready;
      nxt_item_valid = item_valid && !item_ready;
      nxt_cfg_valid  = cfg_valid && !cfg_ready;
      if (took_item) sent_cnt++;
      calm_tx = (sent_cnt >= CALM_LO) && (sent_cnt < CALM_HI);
      if (!nxt_item_valid && !nxt_cfg_valid && cmd_q.size() != 0) begin
        c = cmd_q[0];
        if (c.is_write) begin
          if (results_owed == 0 && !took_item) begin
            cfg_index     <= c.reg_idx;
            cfg_data      <= c.reg_data;
            nxt_cfg_valid = 1'b1;
            void'(cmd_q.pop_front());
          end
        end else if (calm_tx || $urandom_range(99) >= IDLE_PCT) begin
          channel        <= c.ch;
          target         <= c.tgt;
          pilot_speed    <= c.spd;
          nxt_item_valid = 1'b1;
          void'(cmd_q.pop_front());
        end
      end
      item_valid <= nxt_item_valid;
      cfg_valid  <= nxt_cfg_valid;
      if (cmd_q.size() == 0 && !nxt_item_valid && !nxt_cfg_valid) stim_done <= 1'b1;
    end
  end

  // Monitor. It checks the result taken at this edge first, then applies a
  // register write and predicts an item accepted at the same edge, so a
  // result can never be matched against its own item's prediction.
  always @(posedge clk) begin : watch_proc
    motor_out_t want;
    bit         calm_rx;
    if (rst) begin
      result_ready <= 1'b0;
      results_owed <= 0;
      step_front_q = int'(mcps_pkg::FRONT_STEP_RST);
      step_side_q  = int'(mcps_pkg::SIDE_STEP_RST);
      side_hi_q    = int'(mcps_pkg::SIDE_MAX_RST);
      side_lo_q    = int'(mcps_pkg::SIDE_MIN_RST);
      fb_hi_q      = int'(mcps_pkg::FB_MAX_RST);
      fb_lo_q      = int'(mcps_pkg::FB_MIN_RST);
      gain_q       = int'(mcps_pkg::GAIN_RST);
      offset_q     = int'(mcps_pkg::ZERO_OFFSET_RST);
      foreach (lvl_mem[i]) lvl_mem[i] = 0;
    end else begin
      if (result_valid && result_ready) begin
        got_cnt++;
        if (pwm_expect_q.size() == 0) begin
          flag_mismatch($sformatf("result with no item outstanding: pulse_width=%0d level=%0d",
                                  pulse_width, level));
        end else begin
          want = pwm_expect_q.pop_front();
          if (pulse_width !== want.pw)
            flag_mismatch($sformatf("result %0d pulse_width=%0d, wanted %0d",
                                    got_cnt, pulse_width, want.pw));
          if (level !== want.lv)
            flag_mismatch($sformatf("result %0d level=%0d, wanted %0d",
                                    got_cnt, level, want.lv));
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (mcps_pkg::cfg_reg_t'(cfg_index))
          mcps_pkg::REG_FRONT_STEP:
            step_front_q = int'(cfg_data[mcps_pkg::STEP_W-1:0]);
          mcps_pkg::REG_SIDE_STEP:
            step_side_q  = int'(cfg_data[mcps_pkg::STEP_W-1:0]);
          mcps_pkg::REG_SIDE_MAX:
            side_hi_q    = int'($signed(cfg_data[mcps_pkg::LEVEL_W-1:0]));
          mcps_pkg::REG_SIDE_MIN:
            side_lo_q    = int'($signed(cfg_data[mcps_pkg::LEVEL_W-1:0]));
          mcps_pkg::REG_FB_MAX:
            fb_hi_q      = int'($signed(cfg_data[mcps_pkg::LEVEL_W-1:0]));
          mcps_pkg::REG_FB_MIN:
            fb_lo_q      = int'($signed(cfg_data[mcps_pkg::LEVEL_W-1:0]));
          mcps_pkg::REG_GAIN:
            gain_q       = int'(cfg_data[mcps_pkg::GAIN_W-1:0]);
          mcps_pkg::REG_ZERO_OFFSET:
            offset_q     = int'(cfg_data[mcps_pkg::PW_W-1:0]);
          default: ;
        endcase
      end

      if (item_valid && item_ready)
        pwm_expect_q.push_back(slew_and_scale(channel, target, pilot_speed));

      results_owed <= pwm_expect_q.size();
      calm_rx = (got_cnt >= CALM_LO) && (got_cnt < CALM_HI);
      result_ready <= calm_rx || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Builds the whole command list, releases reset, and waits for the end.
  initial begin : main_proc
    int ch;
    int tgt;
    int spd;
    int lo;
    int hi;
    int swap;
    int run_len;
    int made;

    // Directed part, reset register values: the front channel toward both
    // extremes and snapping down, the sides toward one extreme, and zero targets.
    queue_level(mcps_pkg::CH_FRONT, 255, 0);
    queue_level(mcps_pkg::CH_FRONT, 255, 255);
    queue_level(mcps_pkg::CH_FRONT, -255, 0);
    queue_level(mcps_pkg::CH_LEFT, 255, 255);
    queue_level(mcps_pkg::CH_LEFT, 5, 0);
    queue_level(mcps_pkg::CH_RIGHT, -255, -255);
    queue_level(CH_BACK, 1, 0);
    queue_level(CH_BACK, 0, -1);

    // Inverted limits (minimum above maximum wins), the largest steps,
    // and a pulse width that saturates high.
    queue_reg(mcps_pkg::REG_FRONT_STEP, 255);
    queue_reg(mcps_pkg::REG_SIDE_STEP, 255);
    queue_reg(mcps_pkg::REG_SIDE_MAX, -255);
    queue_reg(mcps_pkg::REG_SIDE_MIN, 255);
    queue_reg(mcps_pkg::REG_FB_MAX, -255);
    queue_reg(mcps_pkg::REG_FB_MIN, 255);
    queue_reg(mcps_pkg::REG_GAIN, 255);
    queue_reg(mcps_pkg::REG_ZERO_OFFSET, 65535);
    queue_level(mcps_pkg::CH_FRONT, 255, 0);
    queue_level(mcps_pkg::CH_LEFT, -255, 0);
    queue_level(mcps_pkg::CH_RIGHT, 255, 1);
    queue_level(CH_BACK, 0, 0);

    // Wide limits with a zero offset: coarse steps overshoot the target,
    // negative sums floor the pulse width at zero, and a negative speed
    // pulls the side ceiling down.
    queue_reg(mcps_pkg::REG_FRONT_STEP, 200);
    queue_reg(mcps_pkg::REG_SIDE_STEP, 200);
    queue_reg(mcps_pkg::REG_SIDE_MAX, 255);
    queue_reg(mcps_pkg::REG_SIDE_MIN, -255);
    queue_reg(mcps_pkg::REG_FB_MAX, 255);
    queue_reg(mcps_pkg::REG_FB_MIN, -255);
    queue_reg(mcps_pkg::REG_ZERO_OFFSET, 0);
    queue_level(mcps_pkg::CH_LEFT, 30, 0);
    queue_level(mcps_pkg::CH_LEFT, 30, 0);
    queue_level(mcps_pkg::CH_FRONT, -255, 0);
    queue_level(mcps_pkg::CH_FRONT, 20, 0);
    queue_level(mcps_pkg::CH_FRONT, 20, 0);
    queue_level(CH_BACK, -1, 0);
    queue_level(mcps_pkg::CH_RIGHT, 255, -255);

    // Zero steps: far from the target the level does not move at all.
    queue_reg(mcps_pkg::REG_FRONT_STEP, 0);
    queue_reg(mcps_pkg::REG_SIDE_STEP, 0);
    queue_level(mcps_pkg::CH_FRONT, 255, 0);
    queue_level(CH_BACK, -255, 0);

    // Random phases. Each rewrites every register; the last one returns to
    // the reset values. Most items come in runs that chase one target on one
    // channel so levels travel the full way through the steps and the band.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) begin
        queue_reg(mcps_pkg::REG_FRONT_STEP, int'(mcps_pkg::FRONT_STEP_RST));
        queue_reg(mcps_pkg::REG_SIDE_STEP, int'(mcps_pkg::SIDE_STEP_RST));
        queue_reg(mcps_pkg::REG_SIDE_MAX, int'(mcps_pkg::SIDE_MAX_RST));
        queue_reg(mcps_pkg::REG_SIDE_MIN, int'(mcps_pkg::SIDE_MIN_RST));
        queue_reg(mcps_pkg::REG_FB_MAX, int'(mcps_pkg::FB_MAX_RST));
        queue_reg(mcps_pkg::REG_FB_MIN, int'(mcps_pkg::FB_MIN_RST));
        queue_reg(mcps_pkg::REG_GAIN, int'(mcps_pkg::GAIN_RST));
        queue_reg(mcps_pkg::REG_ZERO_OFFSET, int'(mcps_pkg::ZERO_OFFSET_RST));
      end else begin
        queue_reg(mcps_pkg::REG_FRONT_STEP,
                  ($urandom_range(99) < 60) ? $urandom_range(1, 15) : $urandom_range(255));
        queue_reg(mcps_pkg::REG_SIDE_STEP,
                  ($urandom_range(99) < 60) ? $urandom_range(1, 15) : $urandom_range(255));
        // Limits are usually ordered, sometimes crossed.
        lo = pick_level();
        hi = pick_level();
        if (lo > hi && $urandom_range(99) < 70) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        queue_reg(mcps_pkg::REG_SIDE_MAX, hi);
        queue_reg(mcps_pkg::REG_SIDE_MIN, lo);
        lo = pick_level();
        hi = pick_level();
        if (lo > hi && $urandom_range(99) < 70) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
        queue_reg(mcps_pkg::REG_FB_MAX, hi);
        queue_reg(mcps_pkg::REG_FB_MIN, lo);
        queue_reg(mcps_pkg::REG_GAIN, $urandom_range(255));
        queue_reg(mcps_pkg::REG_ZERO_OFFSET,
                  ($urandom_range(1) != 0) ? $urandom_range(65535)
                                           : $urandom_range(1000, 2000));
      end

      made = 0;
      while (made < PHASE_ITEMS) begin
        ch  = $urandom_range(3);
        tgt = pick_level();
        spd = pick_speed();
        if ($urandom_range(99) < 70) begin
          run_len = $urandom_range(3, 15);
          for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(99) < 15) spd = pick_speed();
            queue_level(ch, tgt, spd);
          end
          made += run_len;
        end else begin
          queue_level(ch, tgt, spd);
          made++;
        end
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (!stim_done);
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Ends a run that never finishes with a failure.
  initial begin : limit_proc
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/mcps_pkg.sv
src/multi_channel_pwm_slew_limiter.sv
tb/tb_top.sv
